[hdl/wfcf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfcf_pkg
// Types and constants for the 802.11 frame capture filter: beat layouts,
// category codes, register indexes and frame-control codes.
// ----------------------------------------------------------------------------
package wfcf_pkg;

	// Longest capture entry in bytes, FCS removed
	localparam logic [11:0] MAX_CAPTURE_BYTES = 12'd1514;

	// Length limits and FCS size in bytes
	localparam logic [11:0] MIN_FRAME_LEN  = 12'd14;
	localparam logic [11:0] MIN_FILTER_LEN = 12'd28;
	localparam logic [11:0] FCS_LEN        = 12'd4;

	// Frame-control codes
	localparam logic [7:0] FC_ACK        = 8'hd4;
	localparam logic [7:0] FC_ASSOC_RSP  = 8'h10;
	localparam logic [7:0] FC_REASSOC_RSP = 8'h30;
	localparam logic [7:0] FC_DISASSOC   = 8'ha0;
	localparam logic [7:0] FC_AUTH       = 8'hb0;
	localparam logic [7:0] FC_DEAUTH     = 8'hc0;
	localparam logic [7:0] FC_TYPE_MASK  = 8'h0c;
	localparam logic [7:0] FC_TYPE_DATA  = 8'h08;
	localparam logic [7:0] FC_DATA       = 8'h08;
	localparam logic [7:0] FC_QOS_DATA   = 8'h88;

	// Result categories
	localparam logic [2:0] CAT_IGNORED   = 3'd0;
	localparam logic [2:0] CAT_ACK       = 3'd1;
	localparam logic [2:0] CAT_MGMT      = 3'd2;
	localparam logic [2:0] CAT_DATA_SEEN = 3'd3;
	localparam logic [2:0] CAT_DATA_KEPT = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_OWN_MAC       = 2'd0;
	localparam logic [1:0] REG_HOST_MAC      = 2'd1;
	localparam logic [1:0] REG_CAPTURE_QUIET = 2'd2;

	typedef struct packed {
		logic [7:0]  frame_control;
		logic [47:0] receiver_addr;
		logic [47:0] transmitter_addr;
		logic [11:0] frame_length;
		logic        queue_has_room;
	} frame_in_t;

	typedef struct packed {
		logic [2:0]  category;
		logic        capture_written;
		logic [11:0] capture_length;
		logic [31:0] ack_count;
		logic [31:0] mgmt_count;
		logic [31:0] data_seen_count;
		logic [31:0] data_kept_count;
		logic [31:0] drop_count;
	} frame_out_t;

endpackage
`default_nettype wire

[hdl/wifi_frame_capture_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wifi_frame_capture_filter
// Classifies received 802.11 frames by frame control, addresses and length,
// keeps five wrapping counters and flags which frames go to the capture queue.
// ----------------------------------------------------------------------------
//
//   channel   signals                      direction   beat
//   in        in_valid/in_stall/in_data    to block    one frame header
//   out       out_valid/out_stall/out_data from block  one classification
//   cfg       cfg_valid/cfg_ready/...      to block    one register write
//
// A frame header is taken into the input stage, classified there and the
// result lands in the output register, one frame per cycle while the output
// is not stalled; the counters are committed as the result moves on.
// Reset clears the counters, the configuration and both stage valids.
// A stalled output holds its beat; the input stage still fills if empty.
// cfg_ready is always high.
module wifi_frame_capture_filter
	import wfcf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire frame_in_t  in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output frame_out_t      out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [47:0] cfg_data
);

	logic        valid_s1;
	frame_in_t   frame_s1;
	logic        out_valid_q;
	frame_out_t  out_q;
	logic [47:0] own_mac_q;
	logic [47:0] host_mac_q;
	logic        quiet_q;
	logic [31:0] acks_q;
	logic [31:0] mgmt_q;
	logic [31:0] dseen_q;
	logic [31:0] dkept_q;
	logic [31:0] drop_q;

	logic        advance;
	logic        accept;
	frame_out_t  result;
	logic        to_us;
	logic        from_host;
	logic        is_mgmt;
	logic        is_data;
	logic        hit_ack;
	logic        hit_mgmt;
	logic        hit_dseen;
	logic        hit_dkept;
	logic        want_capture;
	logic        too_long;
	logic        written;
	logic        dropped;
	logic [11:0] clen;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// Classify the frame held in the input stage
	always_comb begin
		to_us     = frame_s1.receiver_addr == own_mac_q;
		from_host = frame_s1.transmitter_addr == host_mac_q;
		is_mgmt   = frame_s1.frame_control == FC_ASSOC_RSP
			|| frame_s1.frame_control == FC_REASSOC_RSP
			|| frame_s1.frame_control == FC_DISASSOC
			|| frame_s1.frame_control == FC_AUTH
			|| frame_s1.frame_control == FC_DEAUTH;
		is_data   = (frame_s1.frame_control & FC_TYPE_MASK) == FC_TYPE_DATA;
		hit_ack   = 1'b0;
		hit_mgmt  = 1'b0;
		hit_dseen = 1'b0;
		hit_dkept = 1'b0;
		if (frame_s1.frame_length >= MIN_FRAME_LEN) begin
			priority if (frame_s1.frame_control == FC_ACK && to_us) begin
				hit_ack = 1'b1;
			end else if (frame_s1.frame_length >= MIN_FILTER_LEN && from_host) begin
				priority if (is_mgmt && to_us) begin
					hit_mgmt = 1'b1;
				end else if (is_data) begin
					hit_dseen = 1'b1;
					hit_dkept = (frame_s1.frame_control == FC_DATA
						|| frame_s1.frame_control == FC_QOS_DATA) && to_us;
				end else begin
					// other frame types from the host stay ignored
				end
			end else begin
				// short or foreign frames stay ignored
			end
		end
		clen         = frame_s1.frame_length - FCS_LEN;
		too_long     = clen > MAX_CAPTURE_BYTES;
		want_capture = (hit_ack || hit_mgmt || hit_dkept) && !quiet_q;
		dropped      = want_capture && (too_long || !frame_s1.queue_has_room);
		written      = want_capture && !dropped;

		priority if (hit_ack) begin
			result.category = CAT_ACK;
		end else if (hit_mgmt) begin
			result.category = CAT_MGMT;
		end else if (hit_dkept) begin
			result.category = CAT_DATA_KEPT;
		end else if (hit_dseen) begin
			result.category = CAT_DATA_SEEN;
		end else begin
			result.category = CAT_IGNORED;
		end
		result.capture_written = written;
		result.capture_length  = written ? clen : 12'd0;
		result.ack_count       = acks_q + {31'd0, hit_ack};
		result.mgmt_count      = mgmt_q + {31'd0, hit_mgmt};
		result.data_seen_count = dseen_q + {31'd0, hit_dseen};
		result.data_kept_count = dkept_q + {31'd0, hit_dkept};
		result.drop_count      = drop_q + {31'd0, dropped};
	end

	// Hold stage valids, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			own_mac_q   <= '0;
			host_mac_q  <= '0;
			quiet_q     <= 1'b0;
			acks_q      <= '0;
			mgmt_q      <= '0;
			dseen_q     <= '0;
			dkept_q     <= '0;
			drop_q      <= '0;
		end else begin
			// Write configuration
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_OWN_MAC:       own_mac_q  <= cfg_data;
					REG_HOST_MAC:      host_mac_q <= cfg_data;
					REG_CAPTURE_QUIET: quiet_q    <= cfg_data[0];
					default: ;
				endcase
			end
			// Fill the input stage
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			// Advance into the output register and commit counters
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					acks_q  <= result.ack_count;
					mgmt_q  <= result.mgmt_count;
					dseen_q <= result.data_seen_count;
					dkept_q <= result.data_kept_count;
					drop_q  <= result.drop_count;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= in_data;
		end
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

endmodule
`default_nettype wire
